// ===== hdl/pmq_pkg.sv =====
// ----------------------------------------------------------------------------
// Pose matrix to quaternion: shared types and constants
// Field widths, square root pipeline geometry and the per-stage root step.
// ----------------------------------------------------------------------------
`default_nettype none

package pmq_pkg;

   localparam int ANGLE_FRAC_BITS = 14;
   localparam int ROT_W           = 16;
   localparam int POS_W           = 32;
   localparam int MAG_W           = 15;
   localparam int QUAT_W          = 16;

   // one + three rotation terms fits in ROT_W + 3 bits signed
   localparam int SUM_W           = ROT_W + 3;
   localparam int CLAMP_W         = SUM_W - 2;
   localparam int RAD_W           = 32;
   localparam int ROOT_W          = RAD_W / 2;
   localparam int REM_W           = ROOT_W + 2;
   localparam int ACC_W           = REM_W + 2;

   localparam int BITS_PER_STAGE  = 2;
   localparam int SQRT_STAGES     = ROOT_W / BITS_PER_STAGE;

   localparam int REQ_DATA_W      = 240;
   localparam int RSP_DATA_W      = 160;

   localparam logic [MAG_W-1:0]  MAG_ONE = MAG_W'(1 << ANGLE_FRAC_BITS);
   localparam logic [SUM_W-1:0]  SUM_ONE = SUM_W'(1 << ANGLE_FRAC_BITS);
   localparam logic [POS_W-1:0]  POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic [POS_W-1:0]  POS_MAX = {1'b0, {(POS_W-1){1'b1}}};

   // lane order in the pipeline
   localparam int LANE_W = 0;
   localparam int LANE_X = 1;
   localparam int LANE_Y = 2;
   localparam int LANE_Z = 3;
   localparam int NUM_LANES = 4;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;    // radicand bits not yet consumed, msb first
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sq_lane_type;

   typedef struct packed {
      logic [POS_W-1:0]                px;
      logic [POS_W-1:0]                py;
      logic [POS_W-1:0]                pz;
      logic                            neg_x;
      logic                            neg_y;
      logic                            neg_z;
      sq_lane_type [NUM_LANES-1:0]     lane;
   } pipe_type;

   // Digit-by-digit integer square root, BITS_PER_STAGE result bits per call
   function automatic sq_lane_type sq_step(sq_lane_type l);
      sq_lane_type      r;
      logic [ACC_W-1:0] acc;
      logic [ACC_W-1:0] trial;
      r = l;
      for (int k = 0; k < BITS_PER_STAGE; k++) begin
         acc   = {r.rem, r.rad[RAD_W-1 -: 2]};
         trial = {2'b00, r.root, 2'b01};
         if (acc >= trial) begin
            r.rem  = REM_W'(acc - trial);
            r.root = {r.root[ROOT_W-2:0], 1'b1};
         end else begin
            r.rem  = acc[REM_W-1:0];
            r.root = {r.root[ROOT_W-2:0], 1'b0};
         end
         r.rad = {r.rad[RAD_W-3:0], 2'b00};
      end
      return r;
   endfunction

   // Negative sums clamp to zero; otherwise scale by one for the root
   function automatic logic [RAD_W-1:0] radicand(logic [SUM_W-1:0] s);
      logic [RAD_W-1:0] v;
      if (s[SUM_W-1]) begin
         v = '0;
      end else begin
         v = RAD_W'(s[CLAMP_W-1:0]) << ANGLE_FRAC_BITS;
      end
      return v;
   endfunction

   // Halve the root and cap at one
   function automatic logic [MAG_W-1:0] magnitude(logic [ROOT_W-1:0] root);
      logic [MAG_W-1:0] m;
      m = root[ROOT_W-1:1];
      if (m > MAG_ONE) begin
         m = MAG_ONE;
      end
      return m;
   endfunction

   function automatic logic [POS_W-1:0] neg_sat(logic [POS_W-1:0] v);
      logic [POS_W-1:0] n;
      if (v == POS_MIN) begin
         n = POS_MAX;
      end else begin
         n = POS_W'(-v);
      end
      return n;
   endfunction

   // Signed quaternion part from magnitude and sign
   function automatic logic [QUAT_W-1:0] signed_mag(logic [MAG_W-1:0] m, logic neg);
      logic [QUAT_W-1:0] q;
      q = {1'b0, m};
      if (neg) begin
         q = QUAT_W'(-q);
      end
      return q;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/pose_matrix_to_quaternion_core.sv =====
// ----------------------------------------------------------------------------
// Pose matrix to quaternion core
// Converts a 3x4 pose (Q2.14 rotation, Q16.16 translation) to a remapped
// position and quaternion.
// ----------------------------------------------------------------------------
// One item enters per clock when the output is not stalled. The pipeline is
// built around the four parallel square root units: one prep stage forms
// the clamped diagonal sums, eight stages each resolve two root bits, and
// one output register applies halving, the cap at one, the signs and the
// axis remap. Every stage advances on its own, so bubbles collapse and a
// stalled output holds only the stages behind it.
`default_nettype none

module pose_matrix_to_quaternion_core (
   input  wire                                clock,
   input  wire                                reset,
   // req_tdata, lsb first: r00, r01, r02, r10, r11, r12, r20, r21, r22,
   // tx, ty, tz
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [pmq_pkg::REQ_DATA_W-1:0]     req_tdata,
   // rsp_tdata, lsb first: out_px, out_py, out_pz, out_qw, out_qx, out_qy,
   // out_qz, one zero pad bit
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [pmq_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import pmq_pkg::*;

   localparam int LAST = SQRT_STAGES;

   logic [ROT_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
   logic [POS_W-1:0] tx, ty, tz;

   assign r00 = req_tdata[15:0];
   assign r01 = req_tdata[31:16];
   assign r02 = req_tdata[47:32];
   assign r10 = req_tdata[63:48];
   assign r11 = req_tdata[79:64];
   assign r12 = req_tdata[95:80];
   assign r20 = req_tdata[111:96];
   assign r21 = req_tdata[127:112];
   assign r22 = req_tdata[143:128];
   assign tx  = req_tdata[175:144];
   assign ty  = req_tdata[207:176];
   assign tz  = req_tdata[239:208];

   pipe_type              stage_ff [0:LAST];
   pipe_type              stage_in [0:LAST];
   logic [LAST:0]         valid_ff;
   logic [LAST+1:0]       stage_ready;

   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;
   logic                  rsp_valid_ff;

   logic [SUM_W-1:0]      a00, a11, a22;
   logic [SUM_W-1:0]      sum_w, sum_x, sum_y, sum_z;
   logic [ROT_W:0]        diff_x, diff_y, diff_z;
   logic [MAG_W-1:0]      mag_w, mag_x, mag_y, mag_z;

   // Ready chain, from the output register backward
   always_comb begin
      stage_ready[LAST+1] = !rsp_valid_ff || rsp_tready;
      for (int k = LAST; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
   end

   assign req_tready = stage_ready[0];

   // Prep stage: diagonal sums, difference signs, remapped position
   always_comb begin
      a00    = {{(SUM_W-ROT_W){r00[ROT_W-1]}}, r00};
      a11    = {{(SUM_W-ROT_W){r11[ROT_W-1]}}, r11};
      a22    = {{(SUM_W-ROT_W){r22[ROT_W-1]}}, r22};
      sum_w  = SUM_ONE + a00 + a11 + a22;
      sum_x  = SUM_ONE + a00 - a11 - a22;
      sum_y  = SUM_ONE - a00 + a11 - a22;
      sum_z  = SUM_ONE - a00 - a11 + a22;
      diff_x = {r21[ROT_W-1], r21} - {r12[ROT_W-1], r12};
      diff_y = {r02[ROT_W-1], r02} - {r20[ROT_W-1], r20};
      diff_z = {r10[ROT_W-1], r10} - {r01[ROT_W-1], r01};

      stage_in[0].px    = neg_sat(tz);
      stage_in[0].py    = neg_sat(tx);
      stage_in[0].pz    = ty;
      stage_in[0].neg_x = diff_x[ROT_W];
      stage_in[0].neg_y = diff_y[ROT_W];
      stage_in[0].neg_z = diff_z[ROT_W];
      stage_in[0].lane[LANE_W] = '{rad: radicand(sum_w), rem: '0, root: '0};
      stage_in[0].lane[LANE_X] = '{rad: radicand(sum_x), rem: '0, root: '0};
      stage_in[0].lane[LANE_Y] = '{rad: radicand(sum_y), rem: '0, root: '0};
      stage_in[0].lane[LANE_Z] = '{rad: radicand(sum_z), rem: '0, root: '0};

      // Root stages
      for (int k = 1; k <= LAST; k++) begin
         stage_in[k] = stage_ff[k-1];
         for (int j = 0; j < NUM_LANES; j++) begin
            stage_in[k].lane[j] = sq_step(stage_ff[k-1].lane[j]);
         end
      end
   end

   // Output stage: halve, cap, sign and remap (w, -z, -x, y)
   always_comb begin
      mag_w = magnitude(stage_ff[LAST].lane[LANE_W].root);
      mag_x = magnitude(stage_ff[LAST].lane[LANE_X].root);
      mag_y = magnitude(stage_ff[LAST].lane[LANE_Y].root);
      mag_z = magnitude(stage_ff[LAST].lane[LANE_Z].root);
      rsp_data_in = {1'b0,
                     signed_mag(mag_y, stage_ff[LAST].neg_y),
                     signed_mag(mag_x, !stage_ff[LAST].neg_x),
                     signed_mag(mag_z, !stage_ff[LAST].neg_z),
                     mag_w,
                     stage_ff[LAST].pz,
                     stage_ff[LAST].py,
                     stage_ff[LAST].px};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (stage_ready[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int k = 1; k <= LAST; k++) begin
            if (stage_ready[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
         if (stage_ready[LAST+1]) begin
            rsp_valid_ff <= valid_ff[LAST];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= LAST; k++) begin
         if (stage_ready[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
      if (stage_ready[LAST+1]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The final root stage keeps its item while stalled
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff[LAST] && !stage_ready[LAST] |=> valid_ff[LAST])
      else $error("final root stage dropped a stalled item");

   // Completed w and x roots leave a remainder no larger than twice the root
   a_root_rem: assert property (@(posedge clock) disable iff (reset)
      valid_ff[LAST] |->
         (REM_W'(stage_ff[LAST].lane[LANE_W].rem) <=
          REM_W'({stage_ff[LAST].lane[LANE_W].root, 1'b0})) &&
         (REM_W'(stage_ff[LAST].lane[LANE_X].rem) <=
          REM_W'({stage_ff[LAST].lane[LANE_X].root, 1'b0})))
      else $error("square root remainder out of range");

   // w magnitude never exceeds one
   a_qw_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[110:96] <= MAG_ONE)
      else $error("quaternion w above one");

   // An empty prep stage always takes an item
   a_prep_ready: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[0] |-> req_tready)
      else $error("prep stage empty but not ready");

endmodule

`default_nettype wire
